FILE: design/mrc_pkg.sv
// Shared constants and types of the multichannel range conditioner.
`default_nettype none
package mrc_pkg;

  localparam int CHANNELS = 8;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_VALID_MM   = 2'd0,
    REG_ALPHA_Q16      = 2'd1,
    REG_MAX_READ_FAILS = 2'd2
  } cfg_reg_t;

  localparam logic [15:0] MAX_VALID_MM_RESET   = 16'd2000;
  localparam logic [16:0] ALPHA_Q16_RESET      = 17'd13107;
  localparam logic [7:0]  MAX_READ_FAILS_RESET = 8'd2;

  localparam logic [16:0] ALPHA_ONE  = 17'h10000;
  localparam logic [7:0]  FAIL_SAT   = 8'hFF;
  localparam logic [16:0] REPORT_BAD = 17'h1FFFF;

  localparam logic OP_POLL    = 1'b0;
  localparam logic OP_BRINGUP = 1'b1;

endpackage
`default_nettype wire

FILE: design/multichannel_range_conditioner.sv
// Top level of the multichannel range conditioner: per-channel range filter.
//
// Input channel (in_valid / in_stall) carries opcode, channel, read_ok and
// raw_mm; a transfer takes place at a rising edge with in_valid high and
// in_stall low. Output channel (out_valid / out_stall) carries one report per
// item that produces one; polls of absent channels produce none.
// Configuration: cfg_we with cfg_index and cfg_data writes one register
// (0 max_valid_mm, 1 alpha_q16, 2 max_read_fails); index 3 is ignored.
// An accepted item sits in the stage register, where the channel
// state is read and updated and the report formed (one 33x18 multiply for the
// filter step), and its report is then held in the output register: out_valid
// rises when the item moves from the stage register into the output register.
// One item per cycle is sustained while the output is not stalled, including
// back-to-back items on the same channel, since the state is written at the
// edge at which the report is registered.
// A stalled output report is held; the stage keeps its item until the output
// register frees, an empty stage still takes a transfer, and in_stall rises
// only while a full stage is blocked.
// Reset clears all channel state and the pipeline and restores the register
// defaults (2000, 13107, 2).
`default_nettype none
module multichannel_range_conditioner (
  input  wire  logic                          clk,
  input  wire  logic                          rst,
  input  wire  logic                          in_valid,
  output       logic                          in_stall,
  input  wire  logic                          opcode,
  input  wire  logic [2:0]                    channel,
  input  wire  logic                          read_ok,
  input  wire  logic [15:0]                   raw_mm,
  output       logic                          out_valid,
  input  wire  logic                          out_stall,
  output       logic [2:0]                    out_channel,
  output       logic signed [16:0]            raw_report,
  output       logic signed [16:0]            filtered_report,
  output       logic                          reading_valid,
  output       logic                          channel_present,
  input  wire  logic                          cfg_we,
  input  wire  logic [mrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  logic [mrc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mrc_pkg::*;

  // configuration registers
  logic [15:0] max_valid_mm;
  logic [16:0] alpha_q16;
  logic [7:0]  max_read_fails;

  // channel state
  logic [CHANNELS-1:0] present;
  logic [CHANNELS-1:0] primed;
  logic [7:0]          fails  [CHANNELS];
  logic [31:0]         smooth [CHANNELS];

  // stage register
  logic        s_valid;
  logic        s_opcode;
  logic [2:0]  s_channel;
  logic        s_ok;
  logic [15:0] s_raw;

  logic                s_advance;
  logic                s_load;
  logic                s_fire;
  logic                s_in_range;
  logic [CH_IDX_W-1:0] s_idx;

  logic        cur_present;
  logic        cur_primed;
  logic [7:0]  cur_fails;
  logic [31:0] cur_f;

  logic        present_next;
  logic        primed_next;
  logic [7:0]  fails_next;
  logic [31:0] f_next;

  logic               has_result;
  logic [16:0]        raw_rep_next;
  logic [16:0]        filt_rep_next;
  logic               valid_next;

  logic [16:0]        alpha_eff;
  logic signed [32:0] diff;
  logic signed [50:0] prod;
  logic signed [51:0] acc;
  logic [31:0]        f_upd;
  logic [31:0]        f_sample;
  logic [32:0]        f_round;
  logic [7:0]         fails_inc;
  logic               do_filter;
  logic               raw_in_range;

  assign s_advance = !out_valid || !out_stall;
  assign s_load    = !s_valid || s_advance;
  assign in_stall  = !s_load;
  assign s_fire    = s_valid && s_advance;

  assign s_in_range = ({4'b0, s_channel} < 7'(CHANNELS));
  assign s_idx      = CH_IDX_W'(s_channel);

  assign cur_present = present[s_idx];
  assign cur_primed  = primed[s_idx];
  assign cur_fails   = fails[s_idx];
  assign cur_f       = smooth[s_idx];

  // filter step: f + alpha*(target - f) with half-up rounding at 2^-16
  assign alpha_eff = (alpha_q16 > ALPHA_ONE) ? ALPHA_ONE : alpha_q16;
  assign diff      = $signed({1'b0, s_raw, 16'b0}) - $signed({1'b0, cur_f});
  assign prod      = diff * $signed({1'b0, alpha_eff});
  assign acc       = $signed({4'b0, cur_f, 16'b0}) + 52'(prod) + 52'sd32768;
  assign f_upd     = acc[47:16];
  assign f_sample  = cur_primed ? f_upd : {s_raw, 16'b0};
  assign f_round   = {1'b0, f_sample} + 33'd32768;

  assign fails_inc    = (cur_fails == FAIL_SAT) ? FAIL_SAT : cur_fails + 8'd1;
  assign raw_in_range = (s_raw != 16'd0) && (s_raw <= max_valid_mm);

  always_comb begin
    present_next  = cur_present;
    primed_next   = cur_primed;
    fails_next    = cur_fails;
    f_next        = cur_f;
    has_result    = s_in_range;
    raw_rep_next  = REPORT_BAD;
    filt_rep_next = REPORT_BAD;
    valid_next    = 1'b0;
    do_filter     = 1'b0;
    if (s_opcode == OP_BRINGUP) begin
      if (!s_ok) begin
        present_next = 1'b0;
        primed_next  = 1'b0;
        fails_next   = 8'd0;
        f_next       = 32'd0;
      end else begin
        present_next = 1'b1;
        fails_next   = 8'd0;
        raw_rep_next = {1'b0, s_raw};
        do_filter    = 1'b1;
      end
    end else if (!cur_present) begin
      has_result = 1'b0;
    end else if (!s_ok) begin
      fails_next = fails_inc;
      // drop the channel once the failure limit is reached
      if (fails_inc >= max_read_fails) begin
        present_next = 1'b0;
        primed_next  = 1'b0;
        fails_next   = 8'd0;
        f_next       = 32'd0;
      end
    end else begin
      fails_next   = 8'd0;
      raw_rep_next = {1'b0, s_raw};
      do_filter    = raw_in_range;
    end
    if (do_filter) begin
      primed_next   = 1'b1;
      f_next        = f_sample;
      filt_rep_next = f_round[32:16];
      valid_next    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_valid_mm   <= MAX_VALID_MM_RESET;
      alpha_q16      <= ALPHA_Q16_RESET;
      max_read_fails <= MAX_READ_FAILS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_VALID_MM:   max_valid_mm   <= cfg_data[15:0];
        REG_ALPHA_Q16:      alpha_q16      <= cfg_data[16:0];
        REG_MAX_READ_FAILS: max_read_fails <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
      primed  <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        fails[i]  <= 8'd0;
        smooth[i] <= 32'd0;
      end
    end else if (s_fire && s_in_range) begin
      present[s_idx] <= present_next;
      primed[s_idx]  <= primed_next;
      fails[s_idx]   <= fails_next;
      smooth[s_idx]  <= f_next;
    end
  end

  // stage register: hold a full stage while the output register is blocked
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (s_load) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_load) begin
      s_opcode  <= opcode;
      s_channel <= channel;
      s_ok      <= read_ok;
      s_raw     <= raw_mm;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_advance) begin
      out_valid <= s_fire && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && has_result) begin
      out_channel     <= s_channel;
      raw_report      <= $signed(raw_rep_next);
      filtered_report <= $signed(filt_rep_next);
      reading_valid   <= valid_next;
      channel_present <= present_next;
    end
  end

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s_valid && out_valid && out_stall))
    else $error("input stalled without a blocked stage");

  a_valid_report_positive: assert property (@(posedge clk) disable iff (rst)
    (out_valid && reading_valid) |-> !filtered_report[16])
    else $error("valid reading carries a negative filtered value");

  a_invalid_report_marked: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !reading_valid) |-> (filtered_report == -17'sd1))
    else $error("invalid reading not marked with -1");

  a_disabled_not_valid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !channel_present) |-> !reading_valid)
    else $error("disabled channel reported a valid reading");

  a_failed_bringup_clears: assert property (@(posedge clk) disable iff (rst)
    (s_fire && s_in_range && (s_opcode == OP_BRINGUP) && !s_ok)
      |=> (!present[$past(s_idx)] && !primed[$past(s_idx)]))
    else $error("failed bring-up left the channel active");

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench of the multichannel range conditioner.
`timescale 1ns / 100ps

module tb;
  import mrc_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [2:0]  chan;
    logic [16:0] raw_rep;
    logic [16:0] filt_rep;
    logic        valid;
    logic        present;
  } range_report_t;

  class range_scoreboard;
    bit        present [CHANNELS];
    bit        primed  [CHANNELS];
    bit [7:0]  fails   [CHANNELS];
    bit [31:0] smooth  [CHANNELS];
    bit [15:0] max_valid;
    bit [16:0] alpha;
    bit [7:0]  max_fails;
    range_report_t pending_reports[$];
    int errors;

    function new();
      max_valid = MAX_VALID_MM_RESET;
      alpha     = ALPHA_Q16_RESET;
      max_fails = MAX_READ_FAILS_RESET;
      for (int i = 0; i < CHANNELS; i++) clear_channel(i);
      errors = 0;
    endfunction

    function void clear_channel(int ch);
      present[ch] = 0;
      primed[ch]  = 0;
      fails[ch]   = 0;
      smooth[ch]  = 0;
    endfunction

    function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MAX_VALID_MM:   max_valid = data[15:0];
        REG_ALPHA_Q16:      alpha = data;
        REG_MAX_READ_FAILS: max_fails = data[7:0];
        default: ;
      endcase
    endfunction

    // Seed or advance the channel's average; return it rounded to whole mm.
    function bit [16:0] smooth_step(int ch, bit [15:0] raw);
      longint unsigned a, f, target, acc, rounded;
      target = raw;
      target = target << 16;
      if (!primed[ch]) begin
        smooth[ch] = target[31:0];
        primed[ch] = 1;
      end else begin
        a   = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
        f   = smooth[ch];
        acc = f * (64'd65536 - a) + target * a + 64'd32768;
        smooth[ch] = acc[47:16];
      end
      f = smooth[ch];
      rounded = (f + 64'd32768) >> 16;
      return rounded[16:0];
    endfunction

    // Note an accepted transfer; return 1 if it should produce a report.
    function bit note_transfer(bit op, bit [2:0] ch, bit ok, bit [15:0] raw);
      range_report_t rep;
      rep.chan     = ch;
      rep.raw_rep  = REPORT_BAD;
      rep.filt_rep = REPORT_BAD;
      rep.valid    = 0;
      if (op == OP_BRINGUP) begin
        if (!ok) begin
          clear_channel(ch);
        end else begin
          present[ch]  = 1;
          fails[ch]    = 0;
          rep.raw_rep  = {1'b0, raw};
          rep.filt_rep = smooth_step(ch, raw);
          rep.valid    = 1;
        end
      end else begin
        if (!present[ch]) return 0;
        if (!ok) begin
          if (fails[ch] != FAIL_SAT) fails[ch]++;
          if (fails[ch] >= max_fails) clear_channel(ch);
        end else begin
          fails[ch]   = 0;
          rep.raw_rep = {1'b0, raw};
          if (raw != 0 && raw <= max_valid) begin
            rep.filt_rep = smooth_step(ch, raw);
            rep.valid    = 1;
          end
        end
      end
      rep.present = present[ch];
      pending_reports.push_back(rep);
      return 1;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
    endtask

    task check_report(range_report_t got);
      range_report_t want;
      if (pending_reports.size() == 0) begin
        report($sformatf("report on channel %0d with none pending", got.chan));
        return;
      end
      want = pending_reports.pop_front();
      if (got.chan != want.chan)
        report($sformatf("out_channel got %0d want %0d", got.chan, want.chan));
      if (got.raw_rep != want.raw_rep)
        report($sformatf("ch %0d raw_report got %h want %h", want.chan, got.raw_rep,
                         want.raw_rep));
      if (got.filt_rep != want.filt_rep)
        report($sformatf("ch %0d filtered_report got %h want %h", want.chan,
                         got.filt_rep, want.filt_rep));
      if (got.valid != want.valid)
        report($sformatf("ch %0d reading_valid got %0d want %0d", want.chan, got.valid,
                         want.valid));
      if (got.present != want.present)
        report($sformatf("ch %0d channel_present got %0d want %0d", want.chan,
                         got.present, want.present));
    endtask
  endclass

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic                   opcode;
  logic [2:0]             channel;
  logic                   read_ok;
  logic [15:0]            raw_mm;
  logic                   out_valid;
  logic                   out_stall;
  logic [2:0]             out_channel;
  logic signed [16:0]     raw_report;
  logic signed [16:0]     filtered_report;
  logic                   reading_valid;
  logic                   channel_present;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  range_scoreboard sb;
  bit quiet;
  int cycle_count;

  multichannel_range_conditioner dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Receiver back-pressure, held off during the quiet stretch.
  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      out_stall = !quiet && ($urandom_range(0, 99) < 8);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_report({out_channel, raw_report, filtered_report, reading_valid,
                       channel_present});
  end

  // Starts and ends at a falling edge; leaves in_valid high after the transfer.
  task automatic drive_item(input bit op, input bit [2:0] ch, input bit ok,
                            input bit [15:0] raw, output bit made_report);
    while (!quiet && $urandom_range(0, 99) < 8) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    opcode   = op;
    channel  = ch;
    read_ok  = ok;
    raw_mm   = raw;
    do @(posedge clk); while (in_stall);
    made_report = sb.note_transfer(op, ch, ok, raw);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid = 0;
    while (sb.pending_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(input bit [CFG_IDX_W-1:0] idx, input bit [CFG_DATA_W-1:0] data);
    cfg_we    = 1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic set_config(input bit [15:0] mv, input bit [16:0] al, input bit [7:0] mf);
    settle();
    write_cfg(REG_MAX_VALID_MM, {1'b0, mv});
    write_cfg(REG_ALPHA_Q16, al);
    write_cfg(REG_MAX_READ_FAILS, {9'd0, mf});
  endtask

  function automatic bit [15:0] pick_raw();
    bit [15:0] lim;
    lim = sb.max_valid;
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'($urandom_range(0, 65535));
      2:       return lim;
      3:       return lim + 16'd1;
      default: return (lim == 0) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(1, lim));
    endcase
  endfunction

  // Mostly polls of live channels; bring-ups favour absent channels to keep
  // the filters primed.
  task automatic random_phase(input int wanted);
    int made;
    bit op, ok, hit;
    bit [2:0] ch;
    bit [15:0] raw;
    made = 0;
    while (made < wanted) begin
      ch = 3'($urandom_range(0, CHANNELS - 1));
      if ($urandom_range(0, 99) < (sb.present[ch] ? 8 : 50)) begin
        op  = OP_BRINGUP;
        ok  = $urandom_range(0, 99) >= 20;
        raw = ($urandom_range(0, 99) < 70) ? pick_raw() : 16'($urandom_range(0, 65535));
      end else begin
        op  = OP_POLL;
        ok  = $urandom_range(0, 99) >= 12;
        raw = pick_raw();
      end
      drive_item(op, ch, ok, raw, hit);
      if (hit) made++;
    end
  endtask

  initial begin
    bit hit;
    rst         = 1;
    in_valid    = 0;
    opcode      = OP_POLL;
    channel     = 0;
    read_ok     = 0;
    raw_mm      = 0;
    cfg_we      = 0;
    cfg_index   = REG_MAX_VALID_MM;
    cfg_data    = 0;
    quiet       = 0;
    cycle_count = 0;
    sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Register defaults: seeding, range limits, failure disable.
    drive_item(OP_POLL,    3'd0, 1, 16'd500,   hit);
    drive_item(OP_BRINGUP, 3'd0, 1, 16'd100,   hit);
    drive_item(OP_BRINGUP, 3'd0, 1, 16'hFFFF,  hit);
    drive_item(OP_POLL,    3'd0, 1, 16'd0,     hit);
    drive_item(OP_POLL,    3'd0, 1, 16'd2001,  hit);
    drive_item(OP_POLL,    3'd0, 1, 16'd2000,  hit);
    drive_item(OP_POLL,    3'd0, 1, 16'd1,     hit);
    drive_item(OP_POLL,    3'd0, 0, 16'd77,    hit);
    drive_item(OP_POLL,    3'd0, 0, 16'd77,    hit);
    drive_item(OP_POLL,    3'd0, 1, 16'd500,   hit);
    drive_item(OP_BRINGUP, 3'd7, 0, 16'hFFFF,  hit);
    drive_item(OP_BRINGUP, 3'd7, 1, 16'd0,     hit);
    drive_item(OP_POLL,    3'd7, 1, 16'd1234,  hit);
    drive_item(OP_BRINGUP, 3'd3, 1, 16'hFFFF,  hit);
    drive_item(OP_BRINGUP, 3'd3, 0, 16'd0,     hit);

    // Widest range, alpha of one, longest failure run.
    set_config(16'hFFFF, ALPHA_ONE, 8'hFF);
    drive_item(OP_BRINGUP, 3'd1, 1, 16'd10,    hit);
    drive_item(OP_POLL,    3'd1, 1, 16'hFFFF,  hit);
    drive_item(OP_POLL,    3'd1, 0, 16'd0,     hit);
    drive_item(OP_POLL,    3'd1, 0, 16'd0,     hit);
    drive_item(OP_POLL,    3'd1, 1, 16'd40000, hit);

    // Alpha above one, nothing in range, disable on the first failure.
    set_config(16'd0, 17'h1FFFF, 8'd0);
    drive_item(OP_BRINGUP, 3'd2, 1, 16'd300,   hit);
    drive_item(OP_BRINGUP, 3'd2, 1, 16'd700,   hit);
    drive_item(OP_POLL,    3'd2, 1, 16'd1,     hit);
    drive_item(OP_POLL,    3'd2, 0, 16'd1,     hit);

    // Alpha of zero freezes the average.
    set_config(16'd2000, 17'd0, 8'd2);
    drive_item(OP_BRINGUP, 3'd4, 1, 16'd100,   hit);
    drive_item(OP_BRINGUP, 3'd4, 1, 16'd60000, hit);
    drive_item(OP_POLL,    3'd4, 1, 16'd1500,  hit);

    set_config(16'($urandom_range(100, 5000)), 17'($urandom_range(0, 65536)), 8'd3);
    random_phase(130);
    set_config(16'hFFFF, ALPHA_ONE, 8'd1);
    random_phase(130);
    set_config(MAX_VALID_MM_RESET, ALPHA_Q16_RESET, MAX_READ_FAILS_RESET);
    quiet = 1;
    random_phase(130);
    quiet = 0;
    set_config(16'($urandom_range(1, 65535)), 17'($urandom_range(65537, 131071)), 8'd0);
    random_phase(130);
    set_config(16'($urandom_range(0, 65535)), 17'($urandom_range(0, 131071)),
               8'($urandom_range(1, 255)));
    write_cfg(REG_UNUSED, 17'h1FFFF);
    random_phase(130);

    settle();
    if (sb.errors == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule

FILE: files.f
design/mrc_pkg.sv
design/multichannel_range_conditioner.sv
tb/tb.sv
